/* design/cputopo_pkg.sv */
// Package for the CPUID topology rewrite block.
// Payload and topology types, leaf codes and register indexes. No dependencies.
`default_nettype none

package cputopo_pkg;

	localparam int unsigned ID_W = 8;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned LG_W = 4;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 9;

	localparam logic [ID_W-1:0] VCPU_ID_RESET = 8'd0;
	localparam logic [CNT_W-1:0] VCPU_COUNT_RESET = 9'd1;
	localparam logic [CNT_W-1:0] MAX_CORES = 9'd256;

	localparam logic [31:0] LEAF_FEATURES = 32'h0000_0001;
	localparam logic [31:0] LEAF_EXT_TOPO = 32'h0000_000b;
	localparam logic [31:0] LEAF_V2_TOPO = 32'h0000_001f;
	localparam logic [31:0] LEAF_ADDR_SIZE = 32'h8000_0008;
	localparam logic [31:0] LEAF_CACHE_PROPS = 32'h8000_001d;
	localparam logic [31:0] LEAF_EXT_APIC = 32'h8000_001e;

	localparam logic [31:0] TOPO_SUB_SMT = 32'd0;
	localparam logic [31:0] TOPO_SUB_CORE = 32'd1;
	localparam logic [31:0] TOPO_SUB_END = 32'd2;

	localparam logic [31:0] TOPO_ECX_SMT = 32'h0000_0100;
	localparam logic [31:0] TOPO_ECX_CORE = 32'h0000_0201;
	localparam logic [31:0] TOPO_ECX_END = 32'h0000_0002;

	localparam int unsigned HTT_BIT = 28;
	localparam logic [2:0] SHARED_CACHE_LVL = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VCPU_ID = 1'b0,
		CFG_VCPU_COUNT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] leaf;
		logic [31:0] subleaf;
		logic [31:0] in_eax;
		logic [31:0] in_ebx;
		logic [31:0] in_ecx;
		logic [31:0] in_edx;
	} query_t;

	typedef struct packed {
		logic [31:0] out_eax;
		logic [31:0] out_ebx;
		logic [31:0] out_ecx;
		logic [31:0] out_edx;
		logic synthesized;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] n;
		logic [7:0] n_m1;
		logic [7:0] n_sat;
		logic [LG_W-1:0] lg;
		logic multi;
	} topo_t;

	// ceil(log2(m1 + 1)) = bit length of m1
	function automatic logic [LG_W-1:0] bit_len(input logic [7:0] m1);
		logic [LG_W-1:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (m1[i]) begin
				r = LG_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/cpuid_topology_rewrite.sv */
// CPUID topology rewrite, top level: input register, rewrite logic, result register.
// The start transfer is captured in the input register; the result register then drives the result_valid strobe.
// Throughput: one query per cycle; busy is never raised, the receiver cannot stall.
// Reset: arst_n clears both valid flags and restores vcpu_id = 0, vcpu_count = 1.
// Depends on cputopo_pkg, cputopo_cfg, cputopo_rewrite.
`default_nettype none

module cpuid_topology_rewrite (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cputopo_pkg::query_t query,
	output logic result_valid,
	output cputopo_pkg::result_t result,
	input wire logic cfg_we,
	input wire logic [cputopo_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cputopo_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cputopo_pkg::*;

	query_t query_s1;
	logic valid_s1;
	result_t res_comb;
	result_t result_s2;
	logic valid_s2;
	topo_t topo;

	assign busy = 1'b0;

	cputopo_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.topo(topo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			query_s1 <= query;
		end
		if (valid_s1) begin
			result_s2 <= res_comb;
		end
	end

	cputopo_rewrite u_rewrite (
		.q(query_s1),
		.topo(topo),
		.r(res_comb)
	);

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

/* design/cputopo_cfg.sv */
// Configuration registers and derived topology values.
// Depends on cputopo_pkg.
`default_nettype none

module cputopo_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cputopo_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cputopo_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output cputopo_pkg::topo_t topo
);
	import cputopo_pkg::*;

	logic [ID_W-1:0] vcpu_id_q;
	logic [CNT_W-1:0] vcpu_count_q;
	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] n_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcpu_id_q <= VCPU_ID_RESET;
			vcpu_count_q <= VCPU_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VCPU_ID: vcpu_id_q <= cfg_wdata[ID_W-1:0];
				CFG_VCPU_COUNT: vcpu_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp core count to 1..256
	always_comb begin
		if (vcpu_count_q == '0) begin
			n = CNT_W'(1);
		end else if (vcpu_count_q > MAX_CORES) begin
			n = MAX_CORES;
		end else begin
			n = vcpu_count_q;
		end
		n_m1 = n - CNT_W'(1);
		topo.id = vcpu_id_q;
		topo.n = n;
		topo.n_m1 = n_m1[7:0];
		topo.n_sat = n[8] ? 8'hff : n[7:0];
		topo.lg = bit_len(n_m1[7:0]);
		topo.multi = (n_m1 != '0);
	end

endmodule

`default_nettype wire

/* design/cputopo_rewrite.sv */
// Combinational rewrite of one CPUID query's register values.
// Depends on cputopo_pkg.
`default_nettype none

module cputopo_rewrite (
	input wire cputopo_pkg::query_t q,
	input wire cputopo_pkg::topo_t topo,
	output cputopo_pkg::result_t r
);
	import cputopo_pkg::*;

	logic [11:0] share;

	always_comb begin
		r.out_eax = q.in_eax;
		r.out_ebx = q.in_ebx;
		r.out_ecx = q.in_ecx;
		r.out_edx = q.in_edx;
		r.synthesized = 1'b0;
		share = (q.in_eax[7:5] >= SHARED_CACHE_LVL) ? {4'd0, topo.n_m1} : 12'd0;
		case (q.leaf)
			LEAF_FEATURES: begin
				r.out_ebx = {topo.id, topo.n_sat, q.in_ebx[15:0]};
				r.out_edx[HTT_BIT] = topo.multi;
			end
			LEAF_V2_TOPO: begin
				r.out_eax = '0;
				r.out_ebx = '0;
				r.out_ecx = '0;
				r.out_edx = '0;
			end
			LEAF_ADDR_SIZE: begin
				r.out_ecx = {q.in_ecx[31:16], topo.lg, q.in_ecx[11:8], topo.n_m1};
			end
			LEAF_CACHE_PROPS: begin
				if (q.in_eax[4:0] != 5'd0) begin
					r.out_eax = {q.in_eax[31:26], share, q.in_eax[13:0]};
				end
			end
			LEAF_EXT_APIC: begin
				r.out_eax = {24'd0, topo.id};
				r.out_ebx = {24'd0, topo.id};
				r.out_ecx = '0;
			end
			LEAF_EXT_TOPO: begin
				if (q.subleaf < 32'd3) begin
					r.synthesized = 1'b1;
					r.out_edx = {24'd0, topo.id};
					case (q.subleaf)
						TOPO_SUB_SMT: begin
							r.out_eax = '0;
							r.out_ebx = 32'd1;
							r.out_ecx = TOPO_ECX_SMT;
						end
						TOPO_SUB_CORE: begin
							r.out_eax = {28'd0, topo.lg};
							r.out_ebx = {23'd0, topo.n};
							r.out_ecx = TOPO_ECX_CORE;
						end
						default: begin
							r.out_eax = '0;
							r.out_ebx = '0;
							r.out_ecx = TOPO_ECX_END;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* design/cputopo_chk.sv */
// Port-level checker for cpuid_topology_rewrite, attached by bind.
// Depends on cputopo_pkg.
`default_nettype none

module cputopo_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire cputopo_pkg::query_t query,
	input wire logic result_valid,
	input wire cputopo_pkg::result_t result
);
	import cputopo_pkg::*;

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_has_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, 2))
		else $error("result without a query transfer");

	a_v2_topo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(start, 2) && $past(query.leaf, 2) == LEAF_V2_TOPO
		|-> result.out_eax == '0 && result.out_ebx == '0 && result.out_ecx == '0
			&& result.out_edx == '0 && !result.synthesized)
		else $error("leaf 0x1f not cleared");

	a_synth_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.synthesized
		|-> $past(query.leaf, 2) == LEAF_EXT_TOPO && $past(query.subleaf, 2) < 32'd3
			&& result.out_edx[31:8] == '0)
		else $error("synthesized flag on wrong query");

endmodule

bind cpuid_topology_rewrite cputopo_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.query(query),
	.result_valid(result_valid),
	.result(result)
);

`default_nettype wire
